FILE: rtl/tilemap_pixel_generator_with_blink_assert.svh
// ---------------------------------------------------------------------------
// Tilemap pixel generator assertion macros
// Shared assertion wrappers; NO_ASSERTIONS turns every use into nothing.
// ---------------------------------------------------------------------------
`ifndef TILEMAP_PIXEL_GENERATOR_WITH_BLINK_ASSERT_SVH
`define TILEMAP_PIXEL_GENERATOR_WITH_BLINK_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every clock outside reset.
`define TPG_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("tpg assertion failed: same-cycle check");

// Next-cycle implication, checked on every clock outside reset.
`define TPG_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("tpg assertion failed: next-cycle check");

`else

`define TPG_ASSERT_NOW(label, pre, post)
`define TPG_ASSERT_NEXT(label, pre, post)

`endif

`endif

FILE: rtl/tpg_pkg.sv
// ---------------------------------------------------------------------------
// Tilemap pixel generator package
// Shared request and response words, request codes, geometry and helpers.
// ---------------------------------------------------------------------------
package tpg_pkg;

    // Grid and blink geometry.
    localparam int GRID_COLS    = 32;
    localparam int BLINK_PERIOD = 10;
    localparam int CELL_AW      = 10;
    localparam int CELL_COUNT   = 1 << CELL_AW;
    localparam int GLYPH_AW     = 12;
    localparam int GLYPH_DEPTH  = 1 << GLYPH_AW;
    localparam int PLANE_COUNT  = 3;

    // Blink phases at which blinking content disappears, and the start phase.
    localparam logic [3:0] PHASE_LINE_HIDE = 4'd3;
    localparam logic [3:0] PHASE_CHAR_HIDE = 4'd7;
    localparam logic [3:0] PHASE_START     = 4'd0;

    // Request codes.
    localparam logic [2:0] REQ_VIDEO_WR = 3'd0;
    localparam logic [2:0] REQ_CHAR_LD  = 3'd1;
    localparam logic [2:0] REQ_CTRL_WR  = 3'd2;
    localparam logic [2:0] REQ_FRAME    = 3'd3;
    localparam logic [2:0] REQ_RENDER   = 3'd4;

    // Input word.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [13:0] addr;
        logic [7:0]  data;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
    } tpg_req_t;

    // Output word.
    typedef struct packed {
        logic [7:0] pixel_value;
        logic       redraw_needed;
    } tpg_rsp_t;

    // Request context held while the cell memories are read.
    typedef struct packed {
        logic [2:0] req_type;
        logic       ctrl_bit;
        logic [2:0] row;
        logic [2:0] col;
        logic       origin;
    } tpg_stage1_t;

    // Decisions taken by the blink controller for one request.
    typedef struct packed {
        logic shown;
        logic redraw;
        logic pal_high;
    } tpg_blink_res_t;

    // Cell index of a pixel, wrapped to the cell memory size.
    function automatic logic [CELL_AW-1:0] cell_index(input logic [7:0] px,
                                                      input logic [7:0] py);
        logic [CELL_AW:0] prod;
        logic [CELL_AW:0] sum;
        prod = (CELL_AW+1)'(py[7:3]) * (CELL_AW+1)'(GRID_COLS);
        sum  = prod + (CELL_AW+1)'(px[7:3]);
        return sum[CELL_AW-1:0];
    endfunction

endpackage

FILE: rtl/tpg_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one registered read port with read enable.
// ---------------------------------------------------------------------------
module tpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; a read at a written address returns old data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/tpg_video_mem.sv
// ---------------------------------------------------------------------------
// Tilemap video memory
// Tile-code and attribute memories with a clearing sweep after reset.
// ---------------------------------------------------------------------------
module tpg_video_mem
    import tpg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [CELL_AW:0]   wr_addr,
    input  logic [7:0]         wr_data,
    input  logic               rd_en,
    input  logic [CELL_AW-1:0] rd_addr,
    output logic [7:0]         tile_code,
    output logic [7:0]         attr,
    output logic               clear_done
);

    logic [CELL_AW:0]   clr_cnt_reg;
    logic [CELL_AW:0]   clr_cnt_next;
    logic               tile_we;
    logic               attr_we;
    logic [CELL_AW-1:0] waddr;
    logic [7:0]         wdata;

    assign clear_done = clr_cnt_reg[CELL_AW];

    // Clearing sweep counter: one entry of both memories per cycle.
    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        if (!clear_done) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Write port selection: the sweep owns both memories until it finishes.
    always_comb begin
        if (!clear_done) begin
            tile_we = 1'b1;
            attr_we = 1'b1;
            waddr   = clr_cnt_reg[CELL_AW-1:0];
            wdata   = '0;
        end else begin
            tile_we = wr_en && !wr_addr[CELL_AW];
            attr_we = wr_en && wr_addr[CELL_AW];
            waddr   = wr_addr[CELL_AW-1:0];
            wdata   = wr_data;
        end
    end

    tpg_ram #(
        .WIDTH(8),
        .DEPTH(CELL_COUNT)
    ) u_tile_ram (
        .aclk (aclk),
        .we   (tile_we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(tile_code)
    );

    tpg_ram #(
        .WIDTH(8),
        .DEPTH(CELL_COUNT)
    ) u_attr_ram (
        .aclk (aclk),
        .we   (attr_we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(attr)
    );

endmodule

FILE: rtl/tpg_blink.sv
// ---------------------------------------------------------------------------
// Tilemap blink controller
// Blink phase, blink-seen flags, palette high bit and the visibility test.
// ---------------------------------------------------------------------------
module tpg_blink
    import tpg_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  tpg_stage1_t    s1,
    input  logic [7:0]     attr,
    output tpg_blink_res_t res
);

    logic [3:0] phase_reg;
    logic [3:0] phase_next;
    logic       line_seen_reg;
    logic       line_seen_next;
    logic       char_seen_reg;
    logic       char_seen_next;
    logic       pal_high_reg;
    logic       pal_high_next;
    logic [4:0] phase_inc;
    logic       is_render;
    logic       is_tick;
    logic       lblink;
    logic       cblink;

    assign is_render = (s1.req_type == REQ_RENDER);
    assign is_tick   = (s1.req_type == REQ_FRAME);
    assign lblink    = attr[6];
    assign cblink    = attr[7];
    assign phase_inc = {1'b0, phase_reg} + 5'd1;

    // Visibility, redraw report and the next blink state.
    always_comb begin
        res.pal_high = pal_high_reg;
        res.shown    = (!cblink || (phase_reg < PHASE_CHAR_HIDE))
                    && (!(lblink && !s1.row[0]) || (phase_reg < PHASE_LINE_HIDE))
                    && (attr[3:0] != 4'd0);
        res.redraw   = is_tick
                    && ((((line_seen_reg || char_seen_reg) && (phase_reg == PHASE_START)))
                     || (line_seen_reg && (phase_reg == PHASE_LINE_HIDE))
                     || (char_seen_reg && (phase_reg == PHASE_CHAR_HIDE)));

        phase_next     = phase_reg;
        line_seen_next = line_seen_reg;
        char_seen_next = char_seen_reg;
        pal_high_next  = pal_high_reg;
        if (is_tick) begin
            phase_next = (phase_inc >= 5'(BLINK_PERIOD)) ? PHASE_START : phase_inc[3:0];
        end
        if (is_render) begin
            line_seen_next = (line_seen_reg && !s1.origin) || lblink;
            char_seen_next = (char_seen_reg && !s1.origin) || cblink;
        end
        if (s1.req_type == REQ_CTRL_WR) begin
            pal_high_next = s1.ctrl_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PHASE_START;
            line_seen_reg <= 1'b0;
            char_seen_reg <= 1'b0;
            pal_high_reg  <= 1'b0;
        end else if (en) begin
            phase_reg     <= phase_next;
            line_seen_reg <= line_seen_next;
            char_seen_reg <= char_seen_next;
            pal_high_reg  <= pal_high_next;
        end
    end

endmodule

FILE: rtl/tilemap_pixel_generator_with_blink.sv
// ---------------------------------------------------------------------------
// Tilemap pixel generator with blink
// Top level: request pipeline, glyph plane memories and output register.
// ---------------------------------------------------------------------------
// Usage:
// Requests enter on s_req with s_valid/s_ready; each request gives exactly
// one response word on m_rsp with m_valid/m_ready, in request order.
// Requests write tile codes or attributes, load glyph bytes, write the
// control byte, advance the blink phase on a frame tick, or render a pixel.
// The pipeline has three register stages: cell memory read, glyph memory
// read, and the output register. One request is taken every clock while
// s_ready is high. After reset a clearing sweep zeroes the tile and
// attribute memories; s_ready stays low until it finishes. Glyph memory
// is not cleared. When the receiver holds m_ready low with a word waiting,
// the whole pipeline holds and s_ready drops until that word is taken.
// ---------------------------------------------------------------------------
`include "tilemap_pixel_generator_with_blink_assert.svh"

module tilemap_pixel_generator_with_blink
    import tpg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tpg_req_t s_req,
    output logic     m_valid,
    input  logic     m_ready,
    output tpg_rsp_t m_rsp
);

    logic                      adv;
    logic                      s_acc;
    logic                      clear_done;
    logic                      video_we;
    logic [7:0]                tile_code;
    logic [7:0]                attr;
    logic                      p1_valid_reg;
    tpg_stage1_t               p1_reg;
    tpg_stage1_t               p1_next;
    tpg_blink_res_t            blink_res;
    logic [GLYPH_AW-1:0]       glyph_raddr;
    logic [7:0]                glyph_rd [PLANE_COUNT];
    logic                      p2_valid_reg;
    logic                      p2_planes_reg;
    logic [2:0]                p2_col_reg;
    tpg_rsp_t                  p2_rsp_reg;
    tpg_rsp_t                  p2_rsp_next;
    logic [PLANE_COUNT-1:0]    plane_bits;
    tpg_rsp_t                  m_rsp_reg;
    tpg_rsp_t                  m_rsp_next;
    logic                      m_valid_reg;

    // Pipeline advance: the output register is empty or being emptied.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && clear_done;
    assign s_acc   = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    // Stage 0: memory writes and the cell read for the incoming word.
    assign video_we = s_acc && (s_req.req_type == REQ_VIDEO_WR) && (s_req.addr[13:11] == 3'd0);

    tpg_video_mem u_video_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (video_we),
        .wr_addr   (s_req.addr[CELL_AW:0]),
        .wr_data   (s_req.data),
        .rd_en     (adv),
        .rd_addr   (cell_index(s_req.pixel_x, s_req.pixel_y)),
        .tile_code (tile_code),
        .attr      (attr),
        .clear_done(clear_done)
    );

    always_comb begin
        p1_next.req_type = s_req.req_type;
        p1_next.ctrl_bit = s_req.data[3];
        p1_next.row      = s_req.pixel_y[2:0];
        p1_next.col      = s_req.pixel_x[2:0];
        p1_next.origin   = (s_req.pixel_x == 8'd0) && (s_req.pixel_y == 8'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= s_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg <= p1_next;
        end
    end

    // Stage 1: blink decisions and the glyph read.
    tpg_blink u_blink (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (adv && p1_valid_reg),
        .s1     (p1_reg),
        .attr   (attr),
        .res    (blink_res)
    );

    assign glyph_raddr = {attr[4], tile_code, p1_reg.row};

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        tpg_ram #(
            .WIDTH(8),
            .DEPTH(GLYPH_DEPTH)
        ) u_glyph_ram (
            .aclk (aclk),
            .we   (s_acc && (s_req.req_type == REQ_CHAR_LD) && (s_req.addr[13:12] == 2'(p))),
            .waddr(s_req.addr[GLYPH_AW-1:0]),
            .wdata(s_req.data),
            .re   (adv),
            .raddr(glyph_raddr),
            .rdata(glyph_rd[p])
        );
    end

    // Response fields known before the glyph data arrives.
    always_comb begin
        p2_rsp_next.pixel_value   = '0;
        p2_rsp_next.redraw_needed = blink_res.redraw;
        if (p1_reg.req_type == REQ_RENDER) begin
            p2_rsp_next.pixel_value = {blink_res.pal_high, attr[3:0], 3'b000};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (adv) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_rsp_reg    <= p2_rsp_next;
            p2_planes_reg <= (p1_reg.req_type == REQ_RENDER) && blink_res.shown;
            p2_col_reg    <= p1_reg.col;
        end
    end

    // Stage 2: pick the pixel bit of each plane, leftmost pixel in bit 7.
    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            plane_bits[p] = glyph_rd[p][3'd7 - p2_col_reg] && p2_planes_reg;
        end
        m_rsp_next = p2_rsp_reg;
        m_rsp_next.pixel_value[PLANE_COUNT-1:0] = plane_bits;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_rsp_reg <= m_rsp_next;
        end
    end

    // A frame-tick report never carries pixel data.
    `TPG_ASSERT_NOW(a_redraw_pix, m_valid && m_rsp.redraw_needed, m_rsp.pixel_value == '0)
    // A word leaving the glyph stage always lands in the output register.
    `TPG_ASSERT_NEXT(a_p2_to_out, p2_valid_reg && adv, m_valid_reg)
    // The pipeline is empty when the clearing sweep finishes.
    `TPG_ASSERT_NOW(a_clear_empty, $rose(clear_done), !p1_valid_reg && !p2_valid_reg && !m_valid)

endmodule

FILE: test/tilemap_pixel_generator_with_blink_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tilemap pixel generator testbench
// Sends request words through the valid/ready input channel in random bursts
// while the response channel stalls on its own pattern. Each response word is
// checked against a directed-table value or a cycle-free model of the
// tile, attribute and glyph memories, blink state and palette high bit.
// ---------------------------------------------------------------------------
module tilemap_pixel_generator_with_blink_tb;
    import tpg_pkg::*;

    // Request codes the block treats as no-ops.
    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

    localparam int RANDOM_WORDS = 1300;
    localparam int VIDEO_BYTES  = 2 * CELL_COUNT;
    localparam int GLYPH_BYTES  = PLANE_COUNT * GLYPH_DEPTH;
    localparam int ADDR_MAX     = 16383;
    localparam int RDY_SPAN     = 300;

    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_RUNS, RDY_ALTERNATE} rdy_mode_e;

    // One row of the directed stimulus table.
    typedef struct {
        tpg_req_t word;
        bit       typed;
        tpg_rsp_t rsp;
    } stim_row_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    tpg_req_t s_req;
    logic     m_valid;
    logic     m_ready;
    tpg_rsp_t m_rsp;

    // Shadow state of the block.
    bit [7:0] tile_mem [CELL_COUNT];
    bit [7:0] attr_mem [CELL_COUNT];
    bit [7:0] glyph_mem [GLYPH_BYTES];
    bit       glyph_loaded [GLYPH_BYTES];
    bit [3:0] blink_ph;
    bit       pal_high_bit;
    bit       line_seen;
    bit       char_seen;

    tpg_rsp_t  pending_rsp [$];
    stim_row_t stim_rows [$];

    int  err_count;
    int  word_count;
    int  render_count;
    int  rsp_count;
    int  redraw_count;

    // Sender burst state.
    int  burst_left;
    int  idle_gap;
    bit  sending;

    // Receiver stall state.
    int  stall_cycle;
    int  stall_run;
    bit  stall_hold;

    tilemap_pixel_generator_with_blink dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Cell under a pixel, wrapped to the cell memory.
    function automatic int cell_of(input logic [7:0] px, input logic [7:0] py);
        return ((int'(py) >> 3) * GRID_COLS + (int'(px) >> 3)) % CELL_COUNT;
    endfunction

    // Plane-0 glyph byte address for a pixel: tile set bit, tile code, cell row.
    function automatic logic [GLYPH_AW-1:0] glyph_row_addr(input logic [7:0] px,
                                                           input logic [7:0] py);
        int idx;
        idx = cell_of(px, py);
        return {attr_mem[idx][4], tile_mem[idx], py[2:0]};
    endfunction

    // Applies one request word to the shadow state and returns its response.
    function automatic tpg_rsp_t next_response(input tpg_req_t w);
        tpg_rsp_t            r;
        int                  idx;
        int                  k;
        logic [7:0]          attr;
        logic [GLYPH_AW-1:0] g;
        logic [2:0]          planes;
        logic                show;
        r = '0;
        case (w.req_type)
            REQ_VIDEO_WR: begin
                if (w.addr < CELL_COUNT)
                    tile_mem[w.addr] = w.data;
                else if (w.addr < VIDEO_BYTES)
                    attr_mem[w.addr - CELL_COUNT] = w.data;
            end
            REQ_CHAR_LD: begin
                if (w.addr < GLYPH_BYTES) begin
                    glyph_mem[w.addr]    = w.data;
                    glyph_loaded[w.addr] = 1'b1;
                end
            end
            REQ_CTRL_WR: begin
                pal_high_bit = w.data[3];
            end
            REQ_FRAME: begin
                r.redraw_needed = ((line_seen || char_seen) && blink_ph == PHASE_START)
                               || (line_seen && blink_ph == PHASE_LINE_HIDE)
                               || (char_seen && blink_ph == PHASE_CHAR_HIDE);
                blink_ph = (blink_ph == BLINK_PERIOD - 1) ? PHASE_START : blink_ph + 4'd1;
            end
            REQ_RENDER: begin
                idx  = cell_of(w.pixel_x, w.pixel_y);
                attr = attr_mem[idx];
                // The top-left pixel starts a new frame of blink tracking.
                if (w.pixel_x == 8'd0 && w.pixel_y == 8'd0) begin
                    line_seen = 1'b0;
                    char_seen = 1'b0;
                end
                // Attribute bit 6 is line blink, bit 7 char blink, bits 0-3 palette.
                line_seen = line_seen | attr[6];
                char_seen = char_seen | attr[7];
                show = (!attr[7] || blink_ph < PHASE_CHAR_HIDE)
                    && (!attr[6] || w.pixel_y[0] || blink_ph < PHASE_LINE_HIDE)
                    && attr[3:0] != 4'd0;
                planes = '0;
                if (show) begin
                    g = glyph_row_addr(w.pixel_x, w.pixel_y);
                    for (k = 0; k < PLANE_COUNT; k++)
                        planes[k] = glyph_mem[k * GLYPH_DEPTH + g][3'd7 - w.pixel_x[2:0]];
                end
                r.pixel_value = {pal_high_bit, attr[3:0], planes};
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Drives one word and waits for it to be taken, keeping valid up inside a burst.
    task automatic send_word(input tpg_req_t w);
        if (!sending) begin
            repeat (idle_gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= w;
        sending = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        word_count++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 24);
            idle_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            // A zero gap simply starts the next burst without dropping valid.
            if (idle_gap != 0) begin
                s_valid <= 1'b0;
                sending = 1'b0;
            end
        end
    endtask

    // Queues the expected response for a word and sends it. A render is preceded
    // by loads of any glyph bytes it would read that were never written.
    task automatic issue(input tpg_req_t w, input bit typed, input tpg_rsp_t typed_rsp);
        tpg_req_t            ld;
        tpg_rsp_t            pred;
        logic [GLYPH_AW-1:0] g;
        int                  a;
        int                  k;
        if (w.req_type == REQ_RENDER) begin
            g = glyph_row_addr(w.pixel_x, w.pixel_y);
            for (k = 0; k < PLANE_COUNT; k++) begin
                a = k * GLYPH_DEPTH + g;
                if (!glyph_loaded[a]) begin
                    ld          = '0;
                    ld.req_type = REQ_CHAR_LD;
                    ld.addr     = a[13:0];
                    ld.data     = 8'($urandom_range(0, 255));
                    issue(ld, 1'b0, '0);
                end
            end
            render_count++;
        end
        pred = next_response(w);
        pending_rsp.push_back(typed ? typed_rsp : pred);
        send_word(w);
    endtask

    task automatic add_row(input logic [2:0] req, input int addr, input int data,
                           input int px, input int py, input bit typed,
                           input int pix, input bit redraw);
        stim_row_t row;
        row.word.req_type      = req;
        row.word.addr          = addr[13:0];
        row.word.data          = data[7:0];
        row.word.pixel_x       = px[7:0];
        row.word.pixel_y       = py[7:0];
        row.typed              = typed;
        row.rsp.pixel_value    = pix[7:0];
        row.rsp.redraw_needed  = redraw;
        stim_rows.push_back(row);
    endtask

    // Receiver: the stall pattern cycles through always ready, random, runs and alternating modes.
    always @(posedge aclk) begin
        rdy_mode_e mode;
        stall_cycle++;
        mode = rdy_mode_e'((stall_cycle / RDY_SPAN) % 4);
        case (mode)
            RDY_ALWAYS: begin
                m_ready <= 1'b1;
            end
            RDY_RANDOM: begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            RDY_RUNS: begin
                if (stall_run == 0) begin
                    stall_hold = !stall_hold;
                    stall_run  = $urandom_range(1, 16);
                end
                stall_run--;
                m_ready <= stall_hold;
            end
            default: begin
                m_ready <= stall_cycle[0];
            end
        endcase
    end

    // Response checker: every taken word is matched against the oldest expectation.
    always @(posedge aclk) begin
        tpg_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            rsp_count++;
            if (m_rsp.redraw_needed)
                redraw_count++;
            if (pending_rsp.size() == 0) begin
                $error("response word with nothing expected: pixel_value %0h redraw_needed %0b",
                       m_rsp.pixel_value, m_rsp.redraw_needed);
                err_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (m_rsp.pixel_value !== want.pixel_value) begin
                    $error("pixel_value: expected %0h, got %0h",
                           want.pixel_value, m_rsp.pixel_value);
                    err_count++;
                end
                if (m_rsp.redraw_needed !== want.redraw_needed) begin
                    $error("redraw_needed: expected %0b, got %0b",
                           want.redraw_needed, m_rsp.redraw_needed);
                    err_count++;
                end
            end
        end
    end

    // Run limit, far above the slowest legal run including the clearing sweep.
    initial begin
        #1000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        tpg_req_t w;
        int       sel;
        int       n;
        s_valid    = 1'b0;
        s_req      = '0;
        m_ready    = 1'b0;
        aresetn    = 1'b0;
        burst_left = 8;
        idle_gap   = 1;
        sending    = 1'b0;

        // Directed rows: reset contents, address extremes, no-op codes, blinking.
        add_row(REQ_RENDER, 0, 0, 0, 0, 1'b1, 0, 1'b0);
        add_row(REQ_FRAME, 0, 0, 0, 0, 1'b1, 0, 1'b0);
        add_row(REQ_SPARE_FIRST, ADDR_MAX, 8'hFF, 255, 255, 1'b1, 0, 1'b0);
        add_row(REQ_SPARE_LAST, ADDR_MAX, 8'hFF, 255, 255, 1'b1, 0, 1'b0);
        add_row(REQ_VIDEO_WR, VIDEO_BYTES - 1, 8'hFF, 0, 0, 1'b1, 0, 1'b0);
        add_row(REQ_VIDEO_WR, 0, 8'hFF, 0, 0, 1'b1, 0, 1'b0);
        add_row(REQ_VIDEO_WR, CELL_COUNT, 8'h9F, 0, 0, 1'b1, 0, 1'b0);
        add_row(REQ_VIDEO_WR, ADDR_MAX, 8'h00, 0, 0, 1'b1, 0, 1'b0);
        add_row(REQ_VIDEO_WR, VIDEO_BYTES, 8'h55, 0, 0, 1'b1, 0, 1'b0);
        add_row(REQ_CHAR_LD, GLYPH_BYTES - 1, 8'hFF, 0, 0, 1'b1, 0, 1'b0);
        add_row(REQ_CHAR_LD, ADDR_MAX, 8'h00, 0, 0, 1'b1, 0, 1'b0);
        add_row(REQ_CHAR_LD, GLYPH_BYTES, 8'hAA, 0, 0, 1'b1, 0, 1'b0);
        add_row(REQ_CTRL_WR, 0, 8'h08, 0, 0, 1'b1, 0, 1'b0);
        add_row(REQ_RENDER, 0, 0, 255, 255, 1'b0, 0, 1'b0);
        add_row(REQ_RENDER, 0, 0, 0, 0, 1'b0, 0, 1'b0);
        add_row(REQ_CTRL_WR, 0, 8'hF7, 0, 0, 1'b1, 0, 1'b0);
        add_row(REQ_RENDER, 0, 0, 7, 0, 1'b0, 0, 1'b0);
        add_row(REQ_CTRL_WR, 0, 8'hFF, 0, 0, 1'b1, 0, 1'b0);
        for (n = 0; n < 6; n++)
            add_row(REQ_FRAME, 0, 0, 0, 0, 1'b0, 0, 1'b0);
        // Char blink now hides the cell, and the next tick asks for a redraw.
        add_row(REQ_RENDER, 0, 0, 3, 2, 1'b0, 0, 1'b0);
        add_row(REQ_FRAME, 0, 0, 0, 0, 1'b0, 0, 1'b0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i])
            issue(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].rsp);

        // Random part: mostly writes and renders into a small glyph pool so that
        // visible and blinking cells come up often.
        for (n = 0; n < RANDOM_WORDS; n++) begin
            w.addr    = 14'($urandom_range(0, ADDR_MAX));
            w.data    = 8'($urandom_range(0, 255));
            w.pixel_x = 8'($urandom_range(0, 255));
            w.pixel_y = 8'($urandom_range(0, 255));
            sel       = $urandom_range(0, 99);
            if (sel < 42) begin
                w.req_type = REQ_RENDER;
                if (sel < 2) begin
                    w.pixel_x = 8'd0;
                    w.pixel_y = 8'd0;
                end
            end else if (sel < 56) begin
                w.req_type = REQ_FRAME;
            end else if (sel < 78) begin
                w.req_type = REQ_VIDEO_WR;
                if (sel < 76)
                    w.addr = 14'($urandom_range(0, VIDEO_BYTES - 1));
                if (w.addr < CELL_COUNT && $urandom_range(0, 3) != 0)
                    w.data = 8'($urandom_range(0, 7));
            end else if (sel < 88) begin
                w.req_type = REQ_CHAR_LD;
            end else if (sel < 96) begin
                w.req_type = REQ_CTRL_WR;
            end else begin
                w.req_type = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
            end
            issue(w, 1'b0, '0);
        end

        if (sending)
            s_valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("Sent %0d request words, %0d of them pixel renders.",
                 word_count, render_count);
        $display("Checked %0d response words, %0d of them with a redraw request.",
                 rsp_count, redraw_count);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tpg_pkg.sv
rtl/tpg_ram.sv
rtl/tpg_video_mem.sv
rtl/tpg_blink.sv
rtl/tilemap_pixel_generator_with_blink.sv
test/tilemap_pixel_generator_with_blink_tb.sv
